@@ hdl/lps_pkg.sv @@
// Shared constants, register codes and types for the line pattern search unit.
// No dependencies; compile first.
`timescale 1ns / 1ps

package lps_pkg;

   localparam int PATTERN_MAX      = 32;
   localparam int LINE_NUMBER_BITS = 24;
   localparam int BYTE_BITS        = 8;
   localparam int LEN_BITS         = 6;
   localparam int ROW_BITS         = PATTERN_MAX + 1;
   localparam int WORD_COUNT       = 4;
   localparam int BYTES_PER_WORD   = 8;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 64;

   localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [BYTE_BITS-1:0] STAR_BYTE    = 8'd42;
   localparam logic [BYTE_BITS-1:0] QMARK_BYTE   = 8'd63;
   localparam logic [BYTE_BITS-1:0] UPPER_FIRST  = 8'd65;
   localparam logic [BYTE_BITS-1:0] UPPER_LAST   = 8'd90;
   localparam logic [BYTE_BITS-1:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_IGNORE_CASE    = 3'd1,
      CSR_PATTERN_0_7    = 3'd2,
      CSR_PATTERN_8_15   = 3'd3,
      CSR_PATTERN_16_23  = 3'd4,
      CSR_PATTERN_24_31  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LINE_NUMBER_BITS-1:0] line_number;
      logic                        line_matched;
      logic                        final_line;
   } result_type;

   function automatic logic [BYTE_BITS-1:0] fold_byte(logic [BYTE_BITS-1:0] c, logic fold);
      if (fold && c >= UPPER_FIRST && c <= UPPER_LAST) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

@@ hdl/lps_if.sv @@
// Handshake channels for text beats in and line result beats out.
// Depends on lps_pkg for field widths.
`timescale 1ns / 1ps

interface lps_req_if;
   logic                          valid;
   logic                          ready;
   logic [lps_pkg::BYTE_BITS-1:0] text_byte;
   logic                          end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lps_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [lps_pkg::LINE_NUMBER_BITS-1:0] line_number;
   logic                                 line_matched;
   logic                                 final_line;

   modport source (output valid, output line_number, output line_matched, output final_line,
                   input ready);
   modport sink (input valid, input line_number, input line_matched, input final_line,
                 output ready);
endinterface

@@ hdl/line_pattern_search_unit.sv @@
// Line pattern search unit: substring or glob match per text line.
// A text beat is registered in the input stage; any result beat it yields is then queued and offered.
// Throughput: one text beat per cycle while the result queue has room for two beats; a newline
// with end of text yields two result beats, drained one per cycle while the receiver is ready.
// Reset (synchronous): clears configuration, line state, line counter and result queue.
// Depends on lps_pkg and lps_if.
`timescale 1ns / 1ps

module line_pattern_search_unit (
   input  logic                                clock,
   input  logic                                reset,
   lps_req_if.sink                             req_bus,
   lps_rsp_if.source                           rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [lps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lps_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import lps_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;
   localparam int FLAT_BITS   = PATTERN_MAX * BYTE_BITS;

   function automatic logic [ROW_BITS-1:0] propagate_row(logic [PATTERN_MAX-1:0] gen,
                                                         logic [PATTERN_MAX-1:0] prop,
                                                         logic cin);
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      logic [ROW_BITS-1:0] s;
      a = {1'b0, gen | prop};
      b = {1'b0, gen};
      s = a + b + {{PATTERN_MAX{1'b0}}, cin};
      return s ^ a ^ b;
   endfunction

   // configuration
   logic [LEN_BITS-1:0]      len_ff;
   logic                     icase_ff;
   logic [CSR_DATA_BITS-1:0] pat_word_ff [WORD_COUNT];

   // input stage
   logic                 s1_valid_ff;
   logic [BYTE_BITS-1:0] s1_byte_ff;
   logic                 s1_eot_ff;

   // line state
   logic [BYTE_BITS-1:0]        win_ff [PATTERN_MAX];
   logic [LEN_BITS-1:0]         cnt_ff;
   logic                        substr_ff;
   logic [ROW_BITS-1:0]         row_ff;
   logic                        fresh_ff;
   logic [LINE_NUMBER_BITS-1:0] line_ctr_ff;

   // result queue
   result_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff;
   logic [QPTR_BITS-1:0] tail_ff;
   logic [QCNT_BITS-1:0] count_ff;

   logic s1_fire;
   logic req_fire;
   logic pop;

   logic [LEN_BITS-1:0]    plen;
   logic [BYTE_BITS-1:0]   c_fold;
   logic [BYTE_BITS-1:0]   pat [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] in_range;
   logic [PATTERN_MAX-1:0] star_v;
   logic [PATTERN_MAX-1:0] eq_v;
   logic [PATTERN_MAX-1:0] wild_v;
   logic                   wild;
   logic [ROW_BITS-1:0]    start_row;
   logic [ROW_BITS-1:0]    prev_row;
   logic [ROW_BITS-1:0]    adv_row;
   logic [BYTE_BITS-1:0]   win_in [PATTERN_MAX];
   logic [LEN_BITS-1:0]    cnt_in;
   logic [FLAT_BITS-1:0]   rev_flat;
   logic [FLAT_BITS-1:0]   aligned_flat;
   logic [LEN_BITS-1:0]    shamt;
   logic [PATTERN_MAX-1:0] pos_ok;
   logic                   hit;
   logic                   substr_in;
   logic                   matched_cur;
   logic                   matched_after;
   logic                   matched_empty;
   logic                   is_newline;
   result_type             res0;
   result_type             res1;
   logic [1:0]             nres;
   logic [LINE_NUMBER_BITS-1:0] line_next;

   assign s1_fire       = s1_valid_ff && (count_ff <= QCNT_BITS'(QUEUE_DEPTH - 2));
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid        = count_ff != '0;
   assign rsp_bus.line_number  = queue_ff[head_ff].line_number;
   assign rsp_bus.line_matched = queue_ff[head_ff].line_matched;
   assign rsp_bus.final_line   = queue_ff[head_ff].final_line;
   assign pop                  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      plen   = (len_ff > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX) : len_ff;
      c_fold = fold_byte(s1_byte_ff, icase_ff);
      is_newline = s1_byte_ff == NEWLINE_BYTE;

      for (int i = 0; i < PATTERN_MAX; i++) begin
         pat[i]      = fold_byte(pat_word_ff[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * BYTE_BITS
                                 +: BYTE_BITS], icase_ff);
         in_range[i] = LEN_BITS'(i) < plen;
         star_v[i]   = in_range[i] && pat[i] == STAR_BYTE;
         wild_v[i]   = in_range[i] && (pat[i] == STAR_BYTE || pat[i] == QMARK_BYTE);
         eq_v[i]     = in_range[i] && pat[i] != STAR_BYTE
                       && (pat[i] == QMARK_BYTE || pat[i] == c_fold);
         rev_flat[i * BYTE_BITS +: BYTE_BITS] = pat[PATTERN_MAX - 1 - i];
      end
      wild = |wild_v;

      start_row = propagate_row('0, star_v, 1'b1);
      prev_row  = fresh_ff ? start_row : row_ff;
      adv_row   = propagate_row((star_v & prev_row[ROW_BITS-1:1])
                                | (eq_v & prev_row[PATTERN_MAX-1:0]), star_v, 1'b0);

      win_in[0] = c_fold;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         win_in[i] = win_ff[i - 1];
      end
      cnt_in = (cnt_ff == LEN_BITS'(PATTERN_MAX)) ? cnt_ff : cnt_ff + LEN_BITS'(1);

      shamt        = LEN_BITS'(PATTERN_MAX) - plen;
      aligned_flat = rev_flat >> {shamt, 3'b000};
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pos_ok[i] = !in_range[i]
                     || fold_byte(win_in[i], icase_ff)
                        == aligned_flat[i * BYTE_BITS +: BYTE_BITS];
      end
      hit       = plen != '0 && cnt_in >= plen && &pos_ok;
      substr_in = substr_ff || hit;

      matched_cur   = plen != '0 && (wild ? prev_row[plen] : substr_ff);
      matched_after = plen != '0 && (wild ? adv_row[plen] : substr_in);
      matched_empty = plen != '0 && wild && start_row[plen];

      line_next = line_ctr_ff + LINE_NUMBER_BITS'(1);

      res0.line_number  = line_ctr_ff;
      res0.line_matched = is_newline ? matched_cur : matched_after;
      res0.final_line   = !is_newline;
      res1.line_number  = line_next;
      res1.line_matched = matched_empty;
      res1.final_line   = 1'b1;

      if (!s1_fire) begin
         nres = 2'd0;
      end else if (is_newline) begin
         nres = s1_eot_ff ? 2'd2 : 2'd1;
      end else begin
         nres = s1_eot_ff ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         icase_ff    <= 1'b0;
         for (int w = 0; w < WORD_COUNT; w++) begin
            pat_word_ff[w] <= '0;
         end
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < PATTERN_MAX; i++) begin
            win_ff[i] <= '0;
         end
         cnt_ff      <= '0;
         substr_ff   <= 1'b0;
         row_ff      <= '0;
         fresh_ff    <= 1'b1;
         line_ctr_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_PATTERN_LENGTH: len_ff         <= csr_write_data[LEN_BITS-1:0];
               CSR_IGNORE_CASE:    icase_ff       <= csr_write_data[0];
               CSR_PATTERN_0_7:    pat_word_ff[0] <= csr_write_data;
               CSR_PATTERN_8_15:   pat_word_ff[1] <= csr_write_data;
               CSR_PATTERN_16_23:  pat_word_ff[2] <= csr_write_data;
               CSR_PATTERN_24_31:  pat_word_ff[3] <= csr_write_data;
               default: ;
            endcase
         end

         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            s1_byte_ff  <= req_bus.text_byte;
            s1_eot_ff   <= req_bus.end_of_text;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_fire) begin
            if (is_newline || s1_eot_ff) begin
               for (int i = 0; i < PATTERN_MAX; i++) begin
                  win_ff[i] <= '0;
               end
               cnt_ff      <= '0;
               substr_ff   <= 1'b0;
               row_ff      <= '0;
               fresh_ff    <= 1'b1;
               line_ctr_ff <= s1_eot_ff ? '0 : line_next;
            end else begin
               for (int i = 0; i < PATTERN_MAX; i++) begin
                  win_ff[i] <= win_in[i];
               end
               cnt_ff    <= cnt_in;
               substr_ff <= substr_in;
               row_ff    <= adv_row;
               fresh_ff  <= 1'b0;
            end
         end

         if (nres != 2'd0) begin
            queue_ff[tail_ff] <= res0;
         end
         if (nres == 2'd2) begin
            queue_ff[tail_ff + QPTR_BITS'(1)] <= res1;
         end
         tail_ff  <= tail_ff + QPTR_BITS'(nres);
         head_ff  <= head_ff + QPTR_BITS'(pop);
         count_ff <= count_ff + QCNT_BITS'(nres) - QCNT_BITS'(pop);
      end
   end

endmodule

@@ sim/lps_line_checker.sv @@
// Line result checker for the line pattern search unit: watches text beats, register
// writes and result beats, predicts each line's result and compares it on arrival.
// Depends on lps_pkg and the lps_req_if / lps_rsp_if interfaces.
`timescale 1ns / 1ps

module lps_line_checker (
   input  logic                               clock,
   input  logic                               reset,
   lps_req_if                                 text_mon,
   lps_rsp_if                                 line_mon,
   input  logic                               csr_write_enable,
   input  logic [lps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lps_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output int                                 mismatch_count,
   output int                                 awaited_count
);
   import lps_pkg::*;

   logic [LEN_BITS-1:0]         cfg_length;
   logic                        cfg_fold;
   logic [CSR_DATA_BITS-1:0]    cfg_words [WORD_COUNT];

   logic [BYTE_BITS-1:0]        line_window [PATTERN_MAX];
   int                          line_bytes;
   logic                        found_substring;
   logic [ROW_BITS-1:0]         glob_row;
   logic                        line_empty;
   logic [LINE_NUMBER_BITS-1:0] line_index;

   result_type                  awaited_lines [$];
   int                          mismatches = 0;

   function automatic logic [BYTE_BITS-1:0] casefold(input logic [BYTE_BITS-1:0] c);
      if (cfg_fold && c >= UPPER_FIRST && c <= UPPER_LAST) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic int live_length();
      return (cfg_length > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_length);
   endfunction

   function automatic logic [BYTE_BITS-1:0] pattern_char(input int i);
      return casefold(cfg_words[i / BYTES_PER_WORD][BYTE_BITS*(i % BYTES_PER_WORD) +: BYTE_BITS]);
   endfunction

   // row bit j: the line so far matches pattern bytes 0..j-1
   function automatic logic [ROW_BITS-1:0] glob_seed(input int plen);
      logic [ROW_BITS-1:0] row;
      row = ROW_BITS'(1);
      for (int j = 1; j <= plen; j++) begin
         if (pattern_char(j - 1) == STAR_BYTE && row[j - 1]) begin
            row[j] = 1'b1;
         end
      end
      return row;
   endfunction

   function automatic logic [ROW_BITS-1:0] glob_step(input logic [ROW_BITS-1:0] prev,
                                                     input logic [BYTE_BITS-1:0] c,
                                                     input int plen);
      logic [ROW_BITS-1:0]  row;
      logic [BYTE_BITS-1:0] p;
      row = '0;
      for (int j = 1; j <= plen; j++) begin
         p = pattern_char(j - 1);
         if (p == STAR_BYTE) begin
            row[j] = prev[j] | row[j - 1];
         end else if (p == QMARK_BYTE || p == c) begin
            row[j] = prev[j - 1];
         end
      end
      return row;
   endfunction

   function automatic void absorb_byte(input logic [BYTE_BITS-1:0] raw);
      int                   plen;
      logic [BYTE_BITS-1:0] c;
      logic                 hit;
      plen = live_length();
      c = casefold(raw);
      if (line_empty) begin
         glob_row = glob_seed(plen);
         line_empty = 1'b0;
      end
      for (int i = PATTERN_MAX - 1; i > 0; i--) begin
         line_window[i] = line_window[i - 1];
      end
      line_window[0] = c;
      if (line_bytes < PATTERN_MAX) begin
         line_bytes++;
      end
      glob_row = glob_step(glob_row, c, plen);
      if (plen != 0 && line_bytes >= plen) begin
         hit = 1'b1;
         for (int i = 0; i < plen; i++) begin
            if (casefold(line_window[i]) != pattern_char(plen - 1 - i)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            found_substring = 1'b1;
         end
      end
   endfunction

   function automatic void end_line(input logic last);
      int                  plen;
      logic [ROW_BITS-1:0] row;
      logic                wild;
      result_type          r;
      plen = live_length();
      row = line_empty ? glob_seed(plen) : glob_row;
      wild = 1'b0;
      for (int i = 0; i < plen; i++) begin
         if (pattern_char(i) == STAR_BYTE || pattern_char(i) == QMARK_BYTE) begin
            wild = 1'b1;
         end
      end
      r.line_number = line_index;
      r.line_matched = (plen == 0) ? 1'b0 : (wild ? row[plen] : found_substring);
      r.final_line = last;
      awaited_lines.insert(awaited_lines.size(), r);
      line_index++;
      line_bytes = 0;
      found_substring = 1'b0;
      glob_row = '0;
      line_empty = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         line_window[i] = '0;
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type           seen;
      result_type           want;
      logic [BYTE_BITS-1:0] c;
      logic                 eot;
      if (reset) begin
         cfg_length = '0;
         cfg_fold = 1'b0;
         for (int w = 0; w < WORD_COUNT; w++) begin
            cfg_words[w] = '0;
         end
         for (int i = 0; i < PATTERN_MAX; i++) begin
            line_window[i] = '0;
         end
         line_bytes = 0;
         found_substring = 1'b0;
         glob_row = '0;
         line_empty = 1'b1;
         line_index = '0;
         awaited_lines.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PATTERN_LENGTH: cfg_length = csr_write_data[LEN_BITS-1:0];
               CSR_IGNORE_CASE:    cfg_fold = csr_write_data[0];
               CSR_PATTERN_0_7:    cfg_words[0] = csr_write_data;
               CSR_PATTERN_8_15:   cfg_words[1] = csr_write_data;
               CSR_PATTERN_16_23:  cfg_words[2] = csr_write_data;
               CSR_PATTERN_24_31:  cfg_words[3] = csr_write_data;
               default: ;
            endcase
         end
         if (text_mon.valid && text_mon.ready) begin
            c = text_mon.text_byte;
            eot = text_mon.end_of_text;
            if (c == NEWLINE_BYTE) begin
               end_line(1'b0);
            end else begin
               absorb_byte(c);
            end
            if (eot) begin
               end_line(1'b1);
               line_index = '0;
            end
         end
         if (line_mon.valid && line_mon.ready) begin
            seen = {line_mon.line_number, line_mon.line_matched, line_mon.final_line};
            if (awaited_lines.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected line beat: line %0d matched %0b final %0b",
                           $realtime, seen.line_number, seen.line_matched, seen.final_line);
               end
            end else begin
               want = awaited_lines.pop_front();
               if (seen.line_number !== want.line_number
                   || seen.line_matched !== want.line_matched
                   || seen.final_line !== want.final_line) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: line beat mismatch: want line %0d matched %0b final %0b,",
                              $realtime, want.line_number, want.line_matched, want.final_line,
                              " got line %0d matched %0b final %0b",
                              seen.line_number, seen.line_matched, seen.final_line);
                  end
               end
            end
         end
      end
      mismatch_count <= mismatches;
      awaited_count <= awaited_lines.size();
   end

endmodule

@@ sim/tb.sv @@
// Top of the line pattern search testbench: clock, reset, register programming and
// text stimulus with random gaps and stalls; lps_line_checker does the comparison.
// Depends on lps_pkg, lps_if, line_pattern_search_unit and lps_line_checker.
`timescale 1ns / 1ps

module tb;
   import lps_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int ITEM_TARGET  = 800;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_FROM    = 250;
   localparam int CALM_TO      = 450;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   int                        line_mismatches;
   int                        lines_awaited;

   logic [BYTE_BITS-1:0]      pattern_text [PATTERN_MAX];
   logic [LEN_BITS-1:0]       pat_len;
   logic                      fold_on;
   logic [BYTE_BITS-1:0]      text_bytes [$];
   int                        items_sent = 0;
   int                        cycle_count = 0;
   int                        hold_asks = 0;
   int                        holds_done = 0;
   logic                      calm = 1'b0;

   lps_req_if req_bus ();
   lps_rsp_if rsp_bus ();

   line_pattern_search_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   lps_line_checker line_check (
      .clock            (clock),
      .reset            (reset),
      .text_mon         (req_bus),
      .line_mon         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (line_mismatches),
      .awaited_count    (lines_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls, a calm stretch, and long hold-offs on request
   initial begin : receiver
      int hold_left;
      int asks_seen;
      hold_left = 0;
      asks_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != asks_seen) begin
            asks_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= 20);
         end
      end
   end

   function automatic logic [BYTE_BITS-1:0] random_letter();
      logic [BYTE_BITS-1:0] c;
      c = "a" + BYTE_BITS'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) begin
         c = c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pattern_word(input int w);
      logic [CSR_DATA_BITS-1:0] word;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         word[BYTE_BITS*i +: BYTE_BITS] = pattern_text[BYTES_PER_WORD*w + i];
      end
      return word;
   endfunction

   task automatic send_beat(input logic [BYTE_BITS-1:0] b, input logic last);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= b;
      req_bus.end_of_text <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
      calm <= (items_sent >= CALM_FROM && items_sent < CALM_TO);
      @(negedge clock);
   endtask

   task automatic send_string(input string s, input logic eot_on_last);
      for (int k = 0; k < s.len(); k++) begin
         send_beat(s[k], eot_on_last && k == s.len() - 1);
      end
   endtask

   // hold until no line result is outstanding and the pipeline has drained
   task automatic settle();
      wait (lines_awaited == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_BITS-1:0] index,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [LEN_BITS-1:0] len, input logic fold);
      logic [CSR_DATA_BITS-1:0] noise;
      pat_len = len;
      fold_on = fold;
      noise = {$urandom, $urandom};
      put_reg(CSR_PATTERN_LENGTH, {noise[CSR_DATA_BITS-1:LEN_BITS], len});
      put_reg(CSR_IGNORE_CASE, {noise[CSR_DATA_BITS-1:1], fold});
      put_reg(CSR_PATTERN_0_7, pattern_word(0));
      put_reg(CSR_PATTERN_8_15, pattern_word(1));
      put_reg(CSR_PATTERN_16_23, pattern_word(2));
      put_reg(CSR_PATTERN_24_31, pattern_word(3));
      if ($urandom_range(0, 3) == 0) begin
         put_reg($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, {$urandom, $urandom});
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_pattern(input string s);
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pattern_text[i] = (i < s.len()) ? s[i] : BYTE_BITS'($urandom_range(0, 255));
      end
   endtask

   task automatic choose_settings();
      int                   pick;
      logic                 wild_ok;
      logic [BYTE_BITS-1:0] b;
      logic [LEN_BITS-1:0]  len;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         len = '0;
      end else if (pick == 1) begin
         len = LEN_BITS'($urandom_range(PATTERN_MAX + 1, 63));
      end else if (pick == 2) begin
         len = LEN_BITS'(PATTERN_MAX);
      end else if (pick < 14) begin
         len = LEN_BITS'($urandom_range(1, 6));
      end else begin
         len = LEN_BITS'($urandom_range(7, PATTERN_MAX - 1));
      end
      wild_ok = 1'($urandom_range(0, 1));
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            b = random_letter();
         end else if (wild_ok && pick < 75) begin
            b = STAR_BYTE;
         end else if (wild_ok && pick < 85) begin
            b = QMARK_BYTE;
         end else begin
            b = BYTE_BITS'($urandom_range(0, 255));
         end
         pattern_text[i] = b;
      end
      apply_settings(len, 1'($urandom_range(0, 1)));
   endtask

   task automatic add_letters(input int n);
      repeat (n) text_bytes.insert(text_bytes.size(), random_letter());
   endtask

   // mostly lines shaped from the pattern, some with a broken byte, plus noise
   task automatic make_line();
      int                   kind;
      int                   start;
      int                   live;
      logic [BYTE_BITS-1:0] p;
      logic                 letter;
      live = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      start = text_bytes.size();
      kind = $urandom_range(0, 9);
      if (kind >= 1 && kind <= 6 && live > 0) begin
         if ($urandom_range(0, 3) == 0) begin
            add_letters($urandom_range(1, 6));
         end
         for (int i = 0; i < live; i++) begin
            p = pattern_text[i];
            letter = (p >= UPPER_FIRST && p <= UPPER_LAST)
                     || (p >= UPPER_FIRST + CASE_OFFSET && p <= UPPER_LAST + CASE_OFFSET);
            if (p == STAR_BYTE) begin
               add_letters($urandom_range(0, 3));
            end else if (p == QMARK_BYTE) begin
               text_bytes.insert(text_bytes.size(),
                                 $urandom_range(0, 3) ? random_letter()
                                                      : BYTE_BITS'($urandom_range(0, 255)));
            end else if (fold_on && letter && $urandom_range(0, 1)) begin
               text_bytes.insert(text_bytes.size(), p ^ CASE_OFFSET);
            end else begin
               text_bytes.insert(text_bytes.size(), p);
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            add_letters($urandom_range(1, 6));
         end
         if (kind == 6 && text_bytes.size() > start) begin
            text_bytes[$urandom_range(start, text_bytes.size() - 1)] = random_letter();
         end
      end else if (kind == 9) begin
         repeat ($urandom_range(1, 10)) begin
            text_bytes.insert(text_bytes.size(), BYTE_BITS'($urandom_range(0, 255)));
         end
      end else if (kind != 0) begin
         add_letters(($urandom_range(0, 9) == 0) ? $urandom_range(33, 60)
                                                 : $urandom_range(1, 12));
      end
   endtask

   task automatic send_text(input int lines);
      text_bytes.delete();
      repeat (lines) begin
         make_line();
         text_bytes.insert(text_bytes.size(), NEWLINE_BYTE);
      end
      if (text_bytes.size() > 1 && $urandom_range(0, 1)) begin
         void'(text_bytes.pop_back());
      end
      for (int k = 0; k < text_bytes.size(); k++) begin
         send_beat(text_bytes[k], k == text_bytes.size() - 1);
      end
   endtask

   initial begin : stimulus
      logic holding;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = '0;
      req_bus.end_of_text = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      pat_len = '0;
      fold_on = 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pattern_text[i] = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero pattern length, byte extremes, newline closing the text
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(NEWLINE_BYTE, 1'b1);
      req_bus.valid <= 1'b0;

      // lone star matches empty lines
      settle();
      load_pattern("*");
      apply_settings(LEN_BITS'(1), 1'b0);
      send_beat(NEWLINE_BYTE, 1'b1);
      send_string("q", 1'b1);
      req_bus.valid <= 1'b0;

      // oversized length clamps to the full pattern of stars
      settle();
      load_pattern("********************************");
      apply_settings(LEN_BITS'(50), 1'b1);
      send_string("zZ\n", 1'b1);
      req_bus.valid <= 1'b0;

      // registers change in mid line
      settle();
      load_pattern("aB");
      apply_settings(LEN_BITS'(2), 1'b1);
      send_string("xAb", 1'b0);
      req_bus.valid <= 1'b0;
      settle();
      apply_settings(LEN_BITS'(2), 1'b0);
      send_string("\nAB\n", 1'b1);
      req_bus.valid <= 1'b0;

      settle();
      load_pattern("a?c*");
      apply_settings(LEN_BITS'(4), 1'b1);
      send_string("AxC\nabcdd", 1'b1);
      req_bus.valid <= 1'b0;

      while (items_sent < ITEM_TARGET) begin
         settle();
         choose_settings();
         holding = (holds_done < 2 && items_sent >= 500 + 150 * holds_done);
         if (holding) begin
            hold_asks <= hold_asks + 1;
            holds_done++;
         end
         repeat (holding ? 6 : $urandom_range(1, 4)) send_text($urandom_range(1, 8));
         req_bus.valid <= 1'b0;
      end

      wait (lines_awaited == 0);
      repeat (20) @(negedge clock);
      if (line_mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/lps_pkg.sv
hdl/lps_if.sv
hdl/line_pattern_search_unit.sv
sim/lps_line_checker.sv
sim/tb.sv
